// ===== rtl/qau_pkg.sv =====
`default_nettype none

package qau_pkg;

   // default fraction bits of every component
   localparam int unsigned FRAC_BITS_DEF = 12;
   // entries of the queue between front and back
   localparam int unsigned QUEUE_DEPTH_DEF = 4;

   // exact four-term sums of 16x16 products
   localparam int unsigned SUM_W = 34;
   // square root digits, one per stage
   localparam int unsigned ROOT_STAGES = SUM_W / 2;
   // rounded root or length
   localparam int unsigned LEN_W = 18;
   // doubled divisor
   localparam int unsigned DEN_W = LEN_W + 1;
   // numerator 2*|c|*2^F + d
   localparam int unsigned NUM_W = 32;
   // quotient bits, the top one flags saturation
   localparam int unsigned QUO_W = 18;
   localparam int unsigned DIV_STAGES = QUO_W;
   localparam int unsigned DIV_W = NUM_W + QUO_W;

   typedef enum logic [2:0] {
      OP_MUL,
      OP_DOT,
      OP_LEN,
      OP_NORM,
      OP_AXIS,
      OP_NONE
   } op_type;

   typedef struct packed {
      op_type          op;
      logic [3:0][15:0] a;
      logic [3:0][15:0] b;
   } qau_req_type;

   typedef struct packed {
      logic        valid;
      qau_req_type req;
   } qau_slot_type;

endpackage

`default_nettype wire

// ===== rtl/qau_front.sv =====
`default_nettype none

module qau_front
   import qau_pkg::*;
(
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [2:0]         req_kind,
   input  wire logic signed [15:0] req_a_w,
   input  wire logic signed [15:0] req_a_x,
   input  wire logic signed [15:0] req_a_y,
   input  wire logic signed [15:0] req_a_z,
   input  wire logic signed [15:0] req_b_w,
   input  wire logic signed [15:0] req_b_x,
   input  wire logic signed [15:0] req_b_y,
   input  wire logic signed [15:0] req_b_z,
   input  wire logic               full,
   output qau_slot_type            wr
);

   op_type op;

   // map the request kind onto an operation, unused codes do nothing
   always_comb begin
      unique case (req_kind)
         3'd0: op = OP_MUL;
         3'd1: op = OP_DOT;
         3'd2: op = OP_LEN;
         3'd3: op = OP_NORM;
         3'd4: op = OP_AXIS;
         default: op = OP_NONE;
      endcase
   end

   assign req_stall = full;

   always_comb begin
      wr.valid  = req_valid && !full;
      wr.req.op = op;
      wr.req.a  = {req_a_z, req_a_y, req_a_x, req_a_w};
      wr.req.b  = {req_b_z, req_b_y, req_b_x, req_b_w};
   end

endmodule

`default_nettype wire

// ===== rtl/qau_fifo.sv =====
`default_nettype none

module qau_fifo
   import qau_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
)
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire qau_slot_type wr,
   output logic              full,
   output qau_slot_type      rd,
   input  wire logic         pop
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   qau_req_type       mem_ff [DEPTH];
   logic [PTR_W-1:0]  wptr_ff, wptr_in;
   logic [PTR_W-1:0]  rptr_ff, rptr_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              do_pop;

   assign full   = (cnt_ff == CNT_W'(DEPTH));
   assign do_pop = pop && (cnt_ff != '0);

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      cnt_in  = cnt_ff;
      if (wr.valid) begin
         wptr_in = (wptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rptr_ff + PTR_W'(1);
      end
      if (wr.valid && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (!wr.valid && do_pop) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.valid) begin
         mem_ff[wptr_ff] <= wr.req;
      end
   end

   always_comb begin
      rd.valid = (cnt_ff != '0);
      rd.req   = mem_ff[rptr_ff];
   end

endmodule

`default_nettype wire

// ===== rtl/qau_back.sv =====
`default_nettype none

module qau_back
   import qau_pkg::*;
#(
   parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
)
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire qau_slot_type       rd,
   output logic                    pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [15:0]      rsp_res_w,
   output logic signed [15:0]      rsp_res_x,
   output logic signed [15:0]      rsp_res_y,
   output logic signed [15:0]      rsp_res_z,
   output logic signed [21:0]      rsp_scalar_out,
   output logic                    rsp_degenerate
);

   typedef struct packed {
      op_type                     op;
      logic [3:0][15:0]           a;
      logic [3:0][SUM_W-1:0]      h;
      logic [SUM_W-1:0]           dot;
      logic                       dg;
      logic [SUM_W-1:0]           rem;
      logic [SUM_W-1:0]           r;
   } root_type;

   typedef struct packed {
      op_type                     op;
      logic                       dg;
      logic [3:0]                 neg;
      logic [3:0][15:0]           mres;
      logic [21:0]                dres;
      logic [LEN_W-1:0]           len;
      logic [3:0][NUM_W-1:0]      num;
      logic [DEN_W-1:0]           den;
      logic [3:0][QUO_W-1:0]      quo;
   } div_type;

   localparam logic signed [SUM_W-1:0] MAX16 = SUM_W'(32767);
   localparam logic signed [SUM_W-1:0] MIN16 = -SUM_W'(32768);
   localparam logic signed [SUM_W-1:0] MAX22 = SUM_W'(2097151);
   localparam logic signed [SUM_W-1:0] MIN22 = -SUM_W'(2097152);
   localparam logic signed [SUM_W-1:0] ONE_SQ = SUM_W'(1) << (2 * FRAC_BITS);
   localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) << (FRAC_BITS - 1);
   localparam logic [15:0] ONE = 16'(1) << FRAC_BITS;

   function automatic logic signed [SUM_W-1:0] round_q(input logic signed [SUM_W-1:0] v);
      return (v + HALF) >>> FRAC_BITS;
   endfunction

   function automatic logic [15:0] sat16(input logic signed [SUM_W-1:0] v);
      if (v > MAX16) return 16'h7FFF;
      if (v < MIN16) return 16'h8000;
      return v[15:0];
   endfunction

   function automatic logic [21:0] sat22(input logic signed [SUM_W-1:0] v);
      if (v > MAX22) return 22'h1FFFFF;
      if (v < MIN22) return 22'h200000;
      return v[21:0];
   endfunction

   function automatic root_type root_step(input root_type x, input int unsigned k);
      root_type          y;
      logic [SUM_W-1:0]  bitv;
      logic [SUM_W:0]    trial;
      y     = x;
      bitv  = SUM_W'(1) << (2 * (ROOT_STAGES - 1 - k));
      trial = {1'b0, x.r} + {1'b0, bitv};
      if ({1'b0, x.rem} >= trial) begin
         y.rem = x.rem - trial[SUM_W-1:0];
         y.r   = (x.r >> 1) + bitv;
      end else begin
         y.r   = x.r >> 1;
      end
      return y;
   endfunction

   function automatic div_type div_step(input div_type x, input int unsigned j);
      div_type        y;
      logic [DIV_W-1:0] sh;
      y  = x;
      sh = DIV_W'(x.den) << j;
      for (int i = 0; i < 4; i++) begin
         if (DIV_W'(x.num[i]) >= sh) begin
            y.num[i]    = x.num[i] - sh[NUM_W-1:0];
            y.quo[i][j] = 1'b1;
         end
      end
      return y;
   endfunction

   function automatic logic [15:0] quo_res(input logic neg, input logic [QUO_W-1:0] q);
      if (neg) begin
         if (q > QUO_W'(32768)) return 16'h8000;
         return 16'(QUO_W'(0) - q);
      end
      if (q > QUO_W'(32767)) return 16'h7FFF;
      return q[15:0];
   endfunction

   // whole pipeline moves together, held only by a stalled result
   logic en;
   assign en  = !rsp_valid || !rsp_stall;
   assign pop = en && rd.valid;

   // products
   logic                    m_vld_ff;
   op_type                  m_op_ff;
   logic [3:0][15:0]        m_a_ff;
   logic signed [31:0]      m_p_ff [4][4];
   logic signed [31:0]      m_sq_ff [4];

   always_ff @(posedge clock) begin
      if (en) begin
         m_op_ff <= rd.req.op;
         m_a_ff  <= rd.req.a;
         for (int i = 0; i < 4; i++) begin
            m_sq_ff[i] <= $signed(rd.req.a[i]) * $signed(rd.req.a[i]);
            for (int j = 0; j < 4; j++) begin
               m_p_ff[i][j] <= $signed(rd.req.a[i]) * $signed(rd.req.b[j]);
            end
         end
      end
   end

   // sums
   logic                          s_vld_ff;
   op_type                        s_op_ff;
   logic [3:0][15:0]              s_a_ff;
   logic signed [SUM_W-1:0]       s_h_ff [4];
   logic signed [SUM_W-1:0]       s_dot_ff, s_ss_ff, s_t_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s_op_ff  <= m_op_ff;
         s_a_ff   <= m_a_ff;
         s_h_ff[0] <= SUM_W'(m_p_ff[0][0]) - SUM_W'(m_p_ff[1][1])
                    - SUM_W'(m_p_ff[2][2]) - SUM_W'(m_p_ff[3][3]);
         s_h_ff[1] <= SUM_W'(m_p_ff[0][1]) + SUM_W'(m_p_ff[1][0])
                    + SUM_W'(m_p_ff[2][3]) - SUM_W'(m_p_ff[3][2]);
         s_h_ff[2] <= SUM_W'(m_p_ff[0][2]) + SUM_W'(m_p_ff[2][0])
                    + SUM_W'(m_p_ff[3][1]) - SUM_W'(m_p_ff[1][3]);
         s_h_ff[3] <= SUM_W'(m_p_ff[0][3]) + SUM_W'(m_p_ff[3][0])
                    + SUM_W'(m_p_ff[1][2]) - SUM_W'(m_p_ff[2][1]);
         s_dot_ff <= SUM_W'(m_p_ff[0][0]) + SUM_W'(m_p_ff[1][1])
                   + SUM_W'(m_p_ff[2][2]) + SUM_W'(m_p_ff[3][3]);
         s_ss_ff  <= SUM_W'(m_sq_ff[0]) + SUM_W'(m_sq_ff[1])
                   + SUM_W'(m_sq_ff[2]) + SUM_W'(m_sq_ff[3]);
         s_t_ff   <= ONE_SQ - SUM_W'(m_sq_ff[0]);
      end
   end

   // square root, one digit a stage
   root_type                  rt_init;
   root_type                  rt_in [ROOT_STAGES];
   root_type                  rt_ff [ROOT_STAGES];
   logic [ROOT_STAGES-1:0]    rt_vld_ff;

   always_comb begin
      rt_init.op  = s_op_ff;
      rt_init.a   = s_a_ff;
      for (int i = 0; i < 4; i++) rt_init.h[i] = s_h_ff[i];
      rt_init.dot = s_dot_ff;
      rt_init.dg  = ((s_op_ff == OP_NORM) && (s_ss_ff == '0))
                 || ((s_op_ff == OP_AXIS) && (s_t_ff <= 0));
      rt_init.rem = (s_op_ff != OP_AXIS) ? s_ss_ff : ((s_t_ff > 0) ? s_t_ff : '0);
      rt_init.r   = '0;
      rt_in[0] = root_step(rt_init, 0);
      for (int k = 1; k < ROOT_STAGES; k++) rt_in[k] = root_step(rt_ff[k-1], k);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < ROOT_STAGES; k++) rt_ff[k] <= rt_in[k];
      end
   end

   // rounding, saturation and the rounded root
   root_type                rt_last;
   div_type                 pa_in, pa_ff;
   logic                    pa_vld_ff;

   assign rt_last = rt_ff[ROOT_STAGES-1];

   always_comb begin
      pa_in.op   = rt_last.op;
      pa_in.dg   = rt_last.dg;
      for (int i = 0; i < 4; i++) begin
         pa_in.neg[i]  = rt_last.a[i][15];
         pa_in.mres[i] = sat16(round_q($signed(rt_last.h[i])));
         // magnitude kept in the numerator slot until the next stage
         pa_in.num[i]  = NUM_W'(rt_last.a[i][15] ? 17'(0) - 17'($signed(rt_last.a[i]))
                                                 : 17'($signed(rt_last.a[i])));
      end
      pa_in.dres = sat22(round_q($signed(rt_last.dot)));
      pa_in.len  = LEN_W'(rt_last.r) + LEN_W'(rt_last.rem > rt_last.r);
      pa_in.den  = '0;
      pa_in.quo  = '0;
   end

   always_ff @(posedge clock) begin
      if (en) pa_ff <= pa_in;
   end

   // numerators 2*|c|*2^F + d over the divisor 2*d
   div_type                 pb_in, pb_ff;
   logic                    pb_vld_ff;

   always_comb begin
      pb_in = pa_ff;
      for (int i = 0; i < 4; i++) begin
         pb_in.num[i] = (pa_ff.num[i] << (FRAC_BITS + 1)) + NUM_W'(pa_ff.len);
      end
      pb_in.den = {pa_ff.len, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (en) pb_ff <= pb_in;
   end

   // restoring division, one quotient bit a stage
   div_type                 dv_in [DIV_STAGES];
   div_type                 dv_ff [DIV_STAGES];
   logic [DIV_STAGES-1:0]   dv_vld_ff;

   always_comb begin
      dv_in[0] = div_step(pb_ff, DIV_STAGES - 1);
      for (int k = 1; k < DIV_STAGES; k++) dv_in[k] = div_step(dv_ff[k-1], DIV_STAGES - 1 - k);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < DIV_STAGES; k++) dv_ff[k] <= dv_in[k];
      end
   end

   // result selection
   div_type            dl;
   logic [3:0][15:0]   qres;
   logic [15:0]        res_w_in, res_x_in, res_y_in, res_z_in;
   logic [21:0]        scalar_in;
   logic               degen_in;

   assign dl = dv_ff[DIV_STAGES-1];

   always_comb begin
      for (int i = 0; i < 4; i++) qres[i] = quo_res(dl.neg[i], dl.quo[i]);
      res_w_in  = '0;
      res_x_in  = '0;
      res_y_in  = '0;
      res_z_in  = '0;
      scalar_in = '0;
      degen_in  = 1'b0;
      unique case (dl.op)
         OP_MUL: begin
            res_w_in = dl.mres[0];
            res_x_in = dl.mres[1];
            res_y_in = dl.mres[2];
            res_z_in = dl.mres[3];
         end
         OP_DOT: scalar_in = dl.dres;
         OP_LEN: scalar_in = 22'(dl.len);
         OP_NORM: begin
            degen_in = dl.dg;
            if (dl.dg) begin
               res_w_in = ONE;
            end else begin
               res_w_in = qres[0];
               res_x_in = qres[1];
               res_y_in = qres[2];
               res_z_in = qres[3];
            end
         end
         OP_AXIS: begin
            degen_in = dl.dg;
            if (dl.dg) begin
               res_z_in = ONE;
            end else begin
               res_x_in = qres[1];
               res_y_in = qres[2];
               res_z_in = qres[3];
            end
         end
         default: ;
      endcase
   end

   logic               rsp_valid_ff;
   logic [15:0]        res_w_ff, res_x_ff, res_y_ff, res_z_ff;
   logic [21:0]        scalar_ff;
   logic               degen_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         res_w_ff  <= res_w_in;
         res_x_ff  <= res_x_in;
         res_y_ff  <= res_y_in;
         res_z_ff  <= res_z_in;
         scalar_ff <= scalar_in;
         degen_ff  <= degen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff     <= 1'b0;
         s_vld_ff     <= 1'b0;
         rt_vld_ff    <= '0;
         pa_vld_ff    <= 1'b0;
         pb_vld_ff    <= 1'b0;
         dv_vld_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         m_vld_ff     <= rd.valid;
         s_vld_ff     <= m_vld_ff;
         rt_vld_ff    <= {rt_vld_ff[ROOT_STAGES-2:0], s_vld_ff};
         pa_vld_ff    <= rt_vld_ff[ROOT_STAGES-1];
         pb_vld_ff    <= pa_vld_ff;
         dv_vld_ff    <= {dv_vld_ff[DIV_STAGES-2:0], pb_vld_ff};
         rsp_valid_ff <= dv_vld_ff[DIV_STAGES-1];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_res_w      = res_w_ff;
   assign rsp_res_x      = res_x_ff;
   assign rsp_res_y      = res_y_ff;
   assign rsp_res_z      = res_z_ff;
   assign rsp_scalar_out = scalar_ff;
   assign rsp_degenerate = degen_ff;

endmodule

`default_nettype wire

// ===== rtl/quaternion_arithmetic_unit_top.sv =====
// quaternion arithmetic unit, signed fixed point with FRAC_BITS fraction bits
// request channel: req_valid / req_stall with req_kind (0 multiply, 1 dot,
//   2 length, 3 normalize, 4 axis; other codes give an all-zero result)
//   and the two quaternions req_a_* and req_b_*
// result channel: rsp_valid / rsp_stall with rsp_res_*, rsp_scalar_out and
//   rsp_degenerate; exactly one result per request, in request order
// a request is taken on a clock edge with valid high and stall low
// throughput: one request per cycle, sustained while rsp_stall stays low
// from acceptance to rsp_valid a request passes the queue slot, the product
//   and sum stages, 17 square root digit stages, a rounding stage, a numerator
//   stage, 18 divider stages and the result register
// the front decodes and writes a small queue; the back pipeline pulls from it
// when rsp_stall holds a valid result, the whole back pipeline freezes and the
//   result stays unchanged; requests still fill the queue until it is full,
//   then req_stall rises
// reset (synchronous, active high) empties the queue and drops every valid
`default_nettype none

module quaternion_arithmetic_unit_top
   import qau_pkg::*;
#(
   parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF,
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [2:0]         req_kind,
   input  wire logic signed [15:0] req_a_w,
   input  wire logic signed [15:0] req_a_x,
   input  wire logic signed [15:0] req_a_y,
   input  wire logic signed [15:0] req_a_z,
   input  wire logic signed [15:0] req_b_w,
   input  wire logic signed [15:0] req_b_x,
   input  wire logic signed [15:0] req_b_y,
   input  wire logic signed [15:0] req_b_z,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [15:0]      rsp_res_w,
   output logic signed [15:0]      rsp_res_x,
   output logic signed [15:0]      rsp_res_y,
   output logic signed [15:0]      rsp_res_z,
   output logic signed [21:0]      rsp_scalar_out,
   output logic                    rsp_degenerate
);

   // decoded request into the queue
   qau_slot_type wr;
   // queue head towards the back pipeline
   qau_slot_type rd;
   logic         full;
   logic         pop;

   qau_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_kind  (req_kind),
      .req_a_w   (req_a_w),
      .req_a_x   (req_a_x),
      .req_a_y   (req_a_y),
      .req_a_z   (req_a_z),
      .req_b_w   (req_b_w),
      .req_b_x   (req_b_x),
      .req_b_y   (req_b_y),
      .req_b_z   (req_b_z),
      .full      (full),
      .wr        (wr)
   );

   qau_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock (clock),
      .reset (reset),
      .wr    (wr),
      .full  (full),
      .rd    (rd),
      .pop   (pop)
   );

   // products, sums, root, rounding, divider and the result register
   qau_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .rd             (rd),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_res_w      (rsp_res_w),
      .rsp_res_x      (rsp_res_x),
      .rsp_res_y      (rsp_res_y),
      .rsp_res_z      (rsp_res_z),
      .rsp_scalar_out (rsp_scalar_out),
      .rsp_degenerate (rsp_degenerate)
   );

endmodule

`default_nettype wire

// ===== rtl/qau_checker.sv =====
`default_nettype none

module qau_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_stall,
   input wire logic [2:0]         req_kind,
   input wire logic signed [15:0] req_a_w,
   input wire logic signed [15:0] req_a_x,
   input wire logic signed [15:0] req_a_y,
   input wire logic signed [15:0] req_a_z,
   input wire logic signed [15:0] req_b_w,
   input wire logic signed [15:0] req_b_x,
   input wire logic signed [15:0] req_b_y,
   input wire logic signed [15:0] req_b_z,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic signed [15:0] rsp_res_w,
   input wire logic signed [15:0] rsp_res_x,
   input wire logic signed [15:0] rsp_res_y,
   input wire logic signed [15:0] rsp_res_z,
   input wire logic signed [21:0] rsp_scalar_out,
   input wire logic               rsp_degenerate
);

   // no result straight after reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a fallback result carries no scalar and zero x and y
   a_degen_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_scalar_out == 22'sd0 && rsp_res_x == 16'sd0 && rsp_res_y == 16'sd0)
      else $error("fallback result malformed");

   // a stalled result is held
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result dropped");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         $stable(rsp_res_w) && $stable(rsp_res_x) && $stable(rsp_res_y)
         && $stable(rsp_res_z) && $stable(rsp_scalar_out) && $stable(rsp_degenerate))
      else $error("stalled result changed");

   // a stalled request is held by the sender
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=>
         req_valid && $stable(req_kind)
         && $stable(req_a_w) && $stable(req_a_x) && $stable(req_a_y) && $stable(req_a_z)
         && $stable(req_b_w) && $stable(req_b_x) && $stable(req_b_y) && $stable(req_b_z))
      else $error("stalled request changed");

endmodule

bind quaternion_arithmetic_unit_top qau_checker u_qau_checker (.*);

`default_nettype wire

// ===== bench/testbench.sv =====
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import qau_pkg::*;

   localparam int FRAC = 12;
   localparam int PIPE_LATENCY = 40;

   // one request as queued for the driver
   typedef struct {
      logic [2:0]         kind;
      logic signed [15:0] a [4];
      logic signed [15:0] b [4];
   } quat_request;

   // one predicted result
   typedef struct {
      logic signed [15:0] q [4];
      logic signed [21:0] scalar;
      logic               degen;
   } quat_result;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [2:0]         req_kind = '0;
   logic signed [15:0] req_a_w = '0, req_a_x = '0, req_a_y = '0, req_a_z = '0;
   logic signed [15:0] req_b_w = '0, req_b_x = '0, req_b_y = '0, req_b_z = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_res_w, rsp_res_x, rsp_res_y, rsp_res_z;
   logic signed [21:0] rsp_scalar_out;
   logic               rsp_degenerate;

   quat_request pending_requests [$];
   quat_result  expected_results [$];
   int          failures = 0;
   bit          stimulus_done = 1'b0;
   bit          quiet_phase = 1'b0;

   quaternion_arithmetic_unit_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_kind(req_kind),
      .req_a_w(req_a_w), .req_a_x(req_a_x), .req_a_y(req_a_y), .req_a_z(req_a_z),
      .req_b_w(req_b_w), .req_b_x(req_b_x), .req_b_y(req_b_y), .req_b_z(req_b_z),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_res_w(rsp_res_w), .rsp_res_x(rsp_res_x), .rsp_res_y(rsp_res_y),
      .rsp_res_z(rsp_res_z), .rsp_scalar_out(rsp_scalar_out),
      .rsp_degenerate(rsp_degenerate)
   );

   always #4 clock = ~clock;

   // saturate to a signed range
   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // q.2f back to q.f, half rounds up (>>> floors)
   function automatic longint round_half_up(longint v);
      return (v + (longint'(1) << (FRAC - 1))) >>> FRAC;
   endfunction

   // square root rounded to nearest
   function automatic longint nearest_root(longint n);
      longint r;
      r = 0;
      for (int bitpos = 20; bitpos >= 0; bitpos--) begin
         if ((r + (longint'(1) << bitpos)) * (r + (longint'(1) << bitpos)) <= n)
            r = r + (longint'(1) << bitpos);
      end
      if (n - r * r > r) r = r + 1;
      return r;
   endfunction

   // c scaled by 2^f over d, ties away from zero
   function automatic longint scaled_quotient(longint c, longint d);
      longint mag, quo;
      mag = (c < 0 ? -c : c) << FRAC;
      quo = (mag * 2 + d) / (d * 2);
      return c < 0 ? -quo : quo;
   endfunction

   function automatic quat_result quaternion_outcome(quat_request rq);
      quat_result res;
      longint a [4], b [4], acc [4], sum, len, scal;
      for (int i = 0; i < 4; i++) begin
         a[i] = rq.a[i];
         b[i] = rq.b[i];
         res.q[i] = '0;
      end
      scal = 0;
      res.degen = 1'b0;
      case (op_type'(rq.kind))
         OP_MUL: begin
            acc[0] = a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3];
            acc[1] = a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2];
            acc[2] = a[0]*b[2] + a[2]*b[0] + a[3]*b[1] - a[1]*b[3];
            acc[3] = a[0]*b[3] + a[3]*b[0] + a[1]*b[2] - a[2]*b[1];
            for (int i = 0; i < 4; i++)
               res.q[i] = 16'(clamp(round_half_up(acc[i]), -32768, 32767));
         end
         OP_DOT: scal = round_half_up(a[0]*b[0] + a[1]*b[1] + a[2]*b[2] + a[3]*b[3]);
         OP_LEN, OP_NORM: begin
            sum = a[0]*a[0] + a[1]*a[1] + a[2]*a[2] + a[3]*a[3];
            len = nearest_root(sum);
            if (op_type'(rq.kind) == OP_LEN) scal = len;
            else if (sum == 0) begin
               // zero length gives the identity
               res.q[0] = 16'(1 << FRAC);
               res.degen = 1'b1;
            end else begin
               for (int i = 0; i < 4; i++)
                  res.q[i] = 16'(clamp(scaled_quotient(a[i], len), -32768, 32767));
            end
         end
         OP_AXIS: begin
            sum = (longint'(1) << (2 * FRAC)) - a[0]*a[0];
            if (sum <= 0) begin
               // axis falls back to (0,0,1)
               res.q[3] = 16'(1 << FRAC);
               res.degen = 1'b1;
            end else begin
               len = nearest_root(sum);
               for (int i = 1; i < 4; i++)
                  res.q[i] = 16'(clamp(scaled_quotient(a[i], len), -32768, 32767));
            end
         end
         default: ;
      endcase
      res.scalar = 22'(clamp(scal, -2097152, 2097151));
      return res;
   endfunction

   function automatic logic signed [15:0] random_component(int mode);
      case (mode)
         0: return 16'($urandom);
         1: return 16'($signed($urandom_range(0, 8192)) - 4096);
         2: return 16'($signed($urandom_range(0, 512)) - 256);
         default: return ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
      endcase
   endfunction

   task automatic add_request(logic [2:0] kind, logic signed [15:0] aw, ax, ay, az,
                              logic signed [15:0] bw, bx, by, bz);
      quat_request rq;
      rq.kind = kind;
      rq.a[0] = aw; rq.a[1] = ax; rq.a[2] = ay; rq.a[3] = az;
      rq.b[0] = bw; rq.b[1] = bx; rq.b[2] = by; rq.b[3] = bz;
      pending_requests.push_back(rq);
   endtask

   // driver: predicts on acceptance, then offers the next request or idles
   always @(posedge clock) begin
      quat_request rq;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            rq.kind = req_kind;
            rq.a[0] = req_a_w; rq.a[1] = req_a_x; rq.a[2] = req_a_y; rq.a[3] = req_a_z;
            rq.b[0] = req_b_w; rq.b[1] = req_b_x; rq.b[2] = req_b_y; rq.b[3] = req_b_z;
            expected_results.push_back(quaternion_outcome(rq));
         end
         // a held request stays put until taken
         if (!(req_valid && req_stall)) begin
            if (pending_requests.size() > 0 &&
                (quiet_phase || $urandom_range(0, 99) >= 33)) begin
               rq = pending_requests.pop_front();
               req_valid <= 1'b1;
               req_kind  <= rq.kind;
               req_a_w <= rq.a[0]; req_a_x <= rq.a[1]; req_a_y <= rq.a[2]; req_a_z <= rq.a[3];
               req_b_w <= rq.b[0]; req_b_x <= rq.b[1]; req_b_y <= rq.b[2]; req_b_z <= rq.b[3];
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compares each accepted result with the oldest prediction
   always @(posedge clock) begin
      quat_result want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("result with no request outstanding");
               failures++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_res_w !== want.q[0]) begin
                  $error("res_w expected %0d got %0d", want.q[0], rsp_res_w); failures++;
               end
               if (rsp_res_x !== want.q[1]) begin
                  $error("res_x expected %0d got %0d", want.q[1], rsp_res_x); failures++;
               end
               if (rsp_res_y !== want.q[2]) begin
                  $error("res_y expected %0d got %0d", want.q[2], rsp_res_y); failures++;
               end
               if (rsp_res_z !== want.q[3]) begin
                  $error("res_z expected %0d got %0d", want.q[3], rsp_res_z); failures++;
               end
               if (rsp_scalar_out !== want.scalar) begin
                  $error("scalar_out expected %0d got %0d", want.scalar, rsp_scalar_out);
                  failures++;
               end
               if (rsp_degenerate !== want.degen) begin
                  $error("degenerate expected %0b got %0b", want.degen, rsp_degenerate);
                  failures++;
               end
            end
         end
         rsp_stall <= quiet_phase ? 1'b0 : ($urandom_range(0, 99) < 33);
      end
   end

   // stimulus and end of run
   initial begin
      int mode;
      logic [2:0] kind;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, every kind, both fallbacks, unused codes
      add_request(OP_MUL, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                  16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
      add_request(OP_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                  16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
      add_request(OP_MUL, 4096, 0, 0, 0, 100, -200, 300, -400);
      add_request(OP_DOT, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                  16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
      add_request(OP_DOT, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                  16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
      add_request(OP_DOT, 1, -1, 2048, 0, 2048, 1, 1, 0);
      add_request(OP_LEN, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 0, 0, 0, 0);
      add_request(OP_LEN, 0, 0, 0, 0, -1, -1, -1, -1);
      add_request(OP_LEN, 1, 0, 0, 0, 0, 0, 0, 0);
      add_request(OP_NORM, 0, 0, 0, 0, 16'sh7fff, 1, 2, 3);
      add_request(OP_NORM, 1, 0, 0, 0, 0, 0, 0, 0);
      add_request(OP_NORM, 16'sh8000, 16'sh7fff, 0, -5, 0, 0, 0, 0);
      add_request(OP_NORM, 0, 0, 0, -1, 0, 0, 0, 0);
      add_request(OP_AXIS, 4096, 1, 2, 3, 0, 0, 0, 0);
      add_request(OP_AXIS, -4096, 1, 2, 3, 0, 0, 0, 0);
      add_request(OP_AXIS, 16'sh8000, 100, 0, 0, 0, 0, 0, 0);
      add_request(OP_AXIS, 4095, 16'sh7fff, 16'sh8000, 5, 0, 0, 0, 0);
      add_request(OP_AXIS, 0, 16'sh7fff, 16'sh8000, 0, 0, 0, 0, 0);
      add_request(3'd5, 1, 2, 3, 4, 5, 6, 7, 8);
      add_request(3'd6, -1, -1, -1, -1, -1, -1, -1, -1);
      add_request(3'd7, 16'sh7fff, 0, 0, 0, 0, 0, 0, 0);

      // random: mostly valid kinds, mixed magnitudes so saturation and fine rounding
      // both happen
      for (int n = 0; n < 2000; n++) begin
         // a run with no idling on either side
         if (n == 700) begin
            wait (pending_requests.size() == 0);
            quiet_phase = 1'b1;
         end
         if (n == 1100) begin
            wait (pending_requests.size() == 0);
            quiet_phase = 1'b0;
         end
         kind = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                             : 3'($urandom_range(0, 4));
         mode = $urandom_range(0, 9) < 5 ? 0 : $urandom_range(1, 3);
         add_request(kind, random_component(mode), random_component(mode),
                     random_component(mode), random_component(mode),
                     random_component(mode), random_component(mode),
                     random_component(mode), random_component(mode));
      end

      wait (pending_requests.size() == 0);
      @(posedge clock);
      wait (!req_valid && expected_results.size() == 0);
      repeat (PIPE_LATENCY * 2) @(posedge clock);
      stimulus_done = 1'b1;
      if (failures == 0 && expected_results.size() == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

   // watchdog
   initial begin
      #2ms;
      if (!stimulus_done) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

endmodule

`default_nettype wire
